>>> hdl/udd_pkg.sv
// ----------------------------------------------------------------------------
// udd_pkg
// Shared types, digit range table and helper functions for the decimal digit
// classifier.
// ----------------------------------------------------------------------------
package udd_pkg;

  typedef struct packed {
    logic [31:0] utf8_char;
    logic        always_true;
    logic        has_value;
    logic [31:0] base_limit;
  } udd_in_t;

  typedef struct packed {
    logic        is_decimal;
    logic [31:0] digit_value;
  } udd_out_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] digit;
  } udd_match_t;

  localparam logic [31:0] AllOnes      = 32'hffff_ffff;
  localparam logic [31:0] RomanLo      = 32'he285_a000;
  localparam logic [31:0] RomanHi      = 32'he286_8800;
  localparam logic [31:0] RomanSmall   = 32'he285_b000;
  localparam logic [31:0] RomanSixLate = 32'he286_8500;
  localparam logic [31:0] RomanRunSpan = 32'h0000_0800;

  // First code of each ten-digit run, in match priority order
  localparam int unsigned NumRanges = 65;
  localparam logic [31:0] RangeLo [NumRanges] = '{
    32'hd9a00000, 32'hdbb00000, 32'hdf800000,
    32'he0a5a600, 32'he0a7a600, 32'he0a9a600, 32'he0aba600, 32'he0ada600,
    32'he0afa600, 32'he0b1a600, 32'he0b3a600, 32'he0b5a600, 32'he0b7a600,
    32'he0b99000, 32'he0bb9000, 32'he0bca000,
    32'he1818000, 32'he1829000, 32'he19fa000, 32'he1a09000, 32'he1a58600,
    32'he1a79000, 32'he1aa8000, 32'he1aa9000, 32'he1ad9000, 32'he1aeb000,
    32'he1b18000, 32'he1b19000,
    32'hea98a000, 32'heaa39000, 32'heaa48000, 32'heaa79000, 32'heaa7b000,
    32'heaa99000, 32'heaafb000, 32'hefbc9000,
    32'hf09092a0, 32'hf090b4b0,
    32'hf09181a6, 32'hf09183b0, 32'hf09184b6, 32'hf0918790, 32'hf0918bb0,
    32'hf0919190, 32'hf0919390, 32'hf0919990, 32'hf0919b80, 32'hf0919cb0,
    32'hf091a3a0, 32'hf091a590, 32'hf091b190, 32'hf091b590, 32'hf091b6a0,
    32'hf096a9a0, 32'hf096ab80, 32'hf096ad90,
    32'hf09d9f8e, 32'hf09d9f98, 32'hf09d9fa2, 32'hf09d9fac, 32'hf09d9fb6,
    32'hf09e8580,
    32'hf09e8bb0, 32'hf09ea590, 32'hf09fafb0
  };

  // Large numerals, only valid with an all-ones limit
  localparam int unsigned NumBigRomans = 16;
  localparam logic [31:0] BigRomanSeq [NumBigRomans] = '{
    32'he285ac00, 32'he285bc00, 32'he2868600,
    32'he285ad00, 32'he285bd00, 32'he2868300, 32'he2868400,
    32'he285ae00, 32'he285be00,
    32'he285af00, 32'he285bf00, 32'he2868000,
    32'he2868100, 32'he2868200, 32'he2868700, 32'he2868800
  };
  localparam logic [31:0] BigRomanVal [NumBigRomans] = '{
    32'd50, 32'd50, 32'd50,
    32'd100, 32'd100, 32'd100, 32'd100,
    32'd500, 32'd500,
    32'd1000, 32'd1000, 32'd1000,
    32'd5000, 32'd10000, 32'd50000, 32'd100000
  };

  // Last code of a run; the step between digits follows the lead byte
  function automatic logic [31:0] range_hi(input logic [31:0] lo);
    logic [31:0] hi;
    if (lo[31:24] >= 8'hf0) begin
      hi = lo + 32'h0000_0009;
    end else if (lo[31:24] >= 8'he0) begin
      hi = lo + 32'h0000_0900;
    end else begin
      hi = lo + 32'h0009_0000;
    end
    return hi;
  endfunction

  function automatic logic [3:0] range_digit(input logic [31:0] lo, input logic [31:0] diff);
    logic [3:0] d;
    if (lo[31:24] >= 8'hf0) begin
      d = diff[3:0];
    end else if (lo[31:24] >= 8'he0) begin
      d = diff[11:8];
    end else begin
      d = diff[19:16];
    end
    return d;
  endfunction

  // Base check on a matched digit
  function automatic udd_out_t check_digit(input logic [3:0] d, input logic always_true,
                                           input logic has_value, input logic [31:0] lim);
    udd_out_t r;
    logic     pass;
    pass = (d == 4'd0) || (lim == 32'd0) || (lim > {28'd0, d});
    if (!has_value) begin
      r.is_decimal  = 1'b1;
      r.digit_value = lim;
    end else begin
      r.is_decimal  = pass || always_true;
      r.digit_value = pass ? {28'd0, d} : AllOnes;
    end
    return r;
  endfunction

endpackage

>>> hdl/udd_match.sv
// ----------------------------------------------------------------------------
// udd_match
// Matches a packed character against the decimal digit runs; first run wins.
// ----------------------------------------------------------------------------
module udd_match import udd_pkg::*; (
  input  logic [31:0] seq_i,
  output udd_match_t  match_o
);

  logic        found;
  logic [31:0] lo;
  logic [31:0] diff;

  always_comb begin
    found = 1'b0;
    lo    = '0;
    for (int i = 0; i < NumRanges; i++) begin
      if (!found && (seq_i >= RangeLo[i]) && (seq_i <= range_hi(RangeLo[i]))) begin
        found = 1'b1;
        lo    = RangeLo[i];
      end
    end
    diff          = seq_i - lo;
    match_o.hit   = found;
    match_o.digit = range_digit(lo, diff);
  end

endmodule

>>> hdl/udd_roman.sv
// ----------------------------------------------------------------------------
// udd_roman
// Decodes the Roman numeral block; caller qualifies with the block range.
// ----------------------------------------------------------------------------
module udd_roman import udd_pkg::*; (
  input  logic [31:0] seq_i,
  input  logic        always_i,
  input  logic        has_i,
  input  logic [31:0] lim_i,
  output udd_out_t    res_o
);

  localparam logic [31:0] UpperTen    = 32'he285a900;
  localparam logic [31:0] LowerTen    = 32'he285b900;
  localparam logic [31:0] UpperEleven = 32'he285aa00;
  localparam logic [31:0] LowerEleven = 32'he285ba00;
  localparam logic [31:0] UpperTwelve = 32'he285ab00;
  localparam logic [31:0] LowerTwelve = 32'he285bb00;

  logic        big_hit;
  logic [31:0] big_val;
  logic [3:0]  small_digit;

  always_comb begin
    big_hit = 1'b0;
    big_val = '0;
    for (int i = 0; i < NumBigRomans; i++) begin
      if (seq_i == BigRomanSeq[i]) begin
        big_hit = 1'b1;
        big_val = BigRomanVal[i];
      end
    end
  end

  // both one-to-nine runs start on a 4 KiB-aligned code
  assign small_digit = seq_i[11:8] + 4'd1;

  always_comb begin
    res_o.is_decimal  = always_i;
    res_o.digit_value = has_i ? AllOnes : lim_i;
    if (seq_i <= RomanLo + RomanRunSpan) begin
      res_o = check_digit(small_digit, always_i, has_i, lim_i);
    end else if ((seq_i >= RomanSmall) && (seq_i <= RomanSmall + RomanRunSpan)) begin
      res_o = check_digit(small_digit, always_i, has_i, lim_i);
    end else if ((seq_i == RomanSixLate) && (!has_i || (lim_i > 32'd5))) begin
      res_o.is_decimal  = 1'b1;
      res_o.digit_value = has_i ? 32'd6 : lim_i;
    end else if (has_i) begin
      if ((lim_i > 32'd9) && ((seq_i == UpperTen) || (seq_i == LowerTen))) begin
        res_o.is_decimal  = 1'b1;
        res_o.digit_value = 32'd10;
      end else if ((lim_i > 32'd10) && ((seq_i == UpperEleven) || (seq_i == LowerEleven))) begin
        res_o.is_decimal  = 1'b1;
        res_o.digit_value = 32'd11;
      end else if ((lim_i > 32'd11) && ((seq_i == UpperTwelve) || (seq_i == LowerTwelve))) begin
        res_o.is_decimal  = 1'b1;
        res_o.digit_value = 32'd12;
      end else if ((lim_i == AllOnes) && big_hit) begin
        res_o.is_decimal  = 1'b1;
        res_o.digit_value = big_val;
      end
    end
  end

endmodule

>>> hdl/unicode_decimal_digit_classifier.sv
// ----------------------------------------------------------------------------
// unicode_decimal_digit_classifier
// Classifies one packed UTF-8 character per beat as a decimal digit or
// Roman numeral and returns status plus value.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake                payload
//   -------  ---  -----------------------  -----------------------------------
//   in       in   in_valid_i / in_stall_o  in_data_i  (char, flags, limit)
//   out      out  out_valid_o / out_stall_i out_data_o (is_decimal, value)
//
// One beat in, one beat out. A beat goes through the input register, then
// the range/numeral compare into the result register.
// Throughput is one beat per cycle while out_stall_i is low, set by the single compare pass.
// Reset clears both valid flags only; payload registers are not reset.
// An output stall backs up through the input register to in_stall_o; the
// input register still loads while the result register is draining.
module unicode_decimal_digit_classifier import udd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  udd_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output udd_out_t out_data_o
);

  // input register
  logic     s1_valid_q, s1_valid_d;
  udd_in_t  s1_data_q;

  // result register
  logic     out_valid_q, out_valid_d;
  udd_out_t out_data_q, out_data_d;

  logic       in_take;
  logic       out_load;
  udd_match_t match;
  udd_out_t   roman_res;
  logic       in_roman;
  logic       multi_lead;
  logic [7:0] lead;

  // handshake
  assign out_load   = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !out_load;
  assign in_take    = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_take || (s1_valid_q && !out_load);
  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_data_q <= in_data_i;
    end
    if (out_load) begin
      out_data_q <= out_data_d;
    end
  end

  // classification
  udd_match u_match (
    .seq_i   (s1_data_q.utf8_char),
    .match_o (match)
  );

  udd_roman u_roman (
    .seq_i    (s1_data_q.utf8_char),
    .always_i (s1_data_q.always_true),
    .has_i    (s1_data_q.has_value),
    .lim_i    (s1_data_q.base_limit),
    .res_o    (roman_res)
  );

  assign lead       = s1_data_q.utf8_char[31:24];
  assign in_roman   = (s1_data_q.utf8_char >= RomanLo) && (s1_data_q.utf8_char <= RomanHi);
  // two- or three-byte lead: unmatched gives the limit back unchanged
  assign multi_lead = (lead[7:5] == 3'b110) || (lead[7:4] == 4'b1110);

  always_comb begin
    if (match.hit) begin
      out_data_d = check_digit(match.digit, s1_data_q.always_true,
                               s1_data_q.has_value, s1_data_q.base_limit);
    end else if (in_roman) begin
      out_data_d = roman_res;
    end else if (multi_lead) begin
      out_data_d.is_decimal  = 1'b0;
      out_data_d.digit_value = s1_data_q.base_limit;
    end else begin
      out_data_d.is_decimal  = 1'b0;
      out_data_d.digit_value = s1_data_q.has_value ? AllOnes : s1_data_q.base_limit;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // checks
  a_stall_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && out_stall_i) |-> in_stall_o)
    else $error("input not stalled while both stages are full");

  a_take_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> s1_valid_q)
    else $error("accepted beat lost from input register");

  a_load_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q)
    else $error("computed beat lost from result register");

  a_no_false_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_load && !in_take) |=> s1_valid_q)
    else $error("input register dropped a beat");

endmodule
